>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/mdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdr_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WAIT_W     = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLIP_LVL      = 3'd0,
    CFG_MID_LVL       = 3'd1,
    CFG_CEIL_LVL      = 3'd2,
    CFG_SLIP_WAIT     = 3'd3,
    CFG_JUMP_WAIT     = 3'd4,
    CFG_RAMP_INTERVAL = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RAMP = 2'd2
  } phase_e;

  typedef struct packed {
    logic [WAIT_W-1:0] slip_wait;
    logic [WAIT_W-1:0] jump_wait;
    logic [WAIT_W-1:0] ramp_interval;
  } wait_cfg_t;

  localparam int RST_SLIP_LVL = 128;
  localparam int RST_MID_LVL  = 128;
  localparam int RST_CEIL_LVL = 255;
  localparam logic [WAIT_W-1:0] RST_SLIP_WAIT     = 16'd1000;
  localparam logic [WAIT_W-1:0] RST_JUMP_WAIT     = 16'd500;
  localparam logic [WAIT_W-1:0] RST_RAMP_INTERVAL = 16'd50;

endpackage

`default_nettype wire

>>> hdl/motor_duty_ramp_with_slip_wait.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: input stage, then result stage; a transfer in loads the input stage and the item
// moves on when the result stage is empty or its result is taken. Throughput: one item per
// cycle unless out_ready_i stalls; the duty update is a single compare, add and count step.
// Reset: duty, goal and wait count clear to zero and the phase to idle; the configuration
// registers return to their defaults, and both pipeline stages come up empty.
module motor_duty_ramp_with_slip_wait
  import mdr_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  func_i,
  input  wire logic [DUTY_BITS-1:0]  target_duty_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [DUTY_BITS-1:0]  duty_o,
  output logic                       busy_res_o
);

  logic [DUTY_BITS-1:0] slip_lvl, mid_lvl, ceil_lvl;
  wait_cfg_t            wait_cfg;

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_func_q;
  logic [DUTY_BITS-1:0] s1_target_q;
  logic                 out_valid_q, out_valid_d;
  logic                 advance;
  logic                 in_xfer;

  mdr_cfg #(.DUTY_BITS(DUTY_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .slip_lvl_o  (slip_lvl),
    .mid_lvl_o   (mid_lvl),
    .ceil_lvl_o  (ceil_lvl),
    .wait_cfg_o  (wait_cfg)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q   <= func_i;
      s1_target_q <= target_duty_i;
    end
  end

  mdr_step #(.DUTY_BITS(DUTY_BITS)) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .func_i      (s1_func_q),
    .target_i    (s1_target_q),
    .slip_lvl_i  (slip_lvl),
    .mid_lvl_i   (mid_lvl),
    .ceil_lvl_i  (ceil_lvl),
    .wait_cfg_i  (wait_cfg),
    .duty_o      (duty_o),
    .busy_o      (busy_res_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/mdr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mdr_cfg
  import mdr_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic      [DUTY_BITS-1:0]  slip_lvl_o,
  output logic      [DUTY_BITS-1:0]  mid_lvl_o,
  output logic      [DUTY_BITS-1:0]  ceil_lvl_o,
  output wait_cfg_t                  wait_cfg_o
);

  logic [DUTY_BITS-1:0] slip_lvl_q, mid_lvl_q, ceil_lvl_q;
  wait_cfg_t            wait_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_lvl_q               <= DUTY_BITS'(RST_SLIP_LVL);
      mid_lvl_q                <= DUTY_BITS'(RST_MID_LVL);
      ceil_lvl_q               <= DUTY_BITS'(RST_CEIL_LVL);
      wait_cfg_q.slip_wait     <= RST_SLIP_WAIT;
      wait_cfg_q.jump_wait     <= RST_JUMP_WAIT;
      wait_cfg_q.ramp_interval <= RST_RAMP_INTERVAL;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SLIP_LVL:      slip_lvl_q               <= cfg_wdata_i[DUTY_BITS-1:0];
        CFG_MID_LVL:       mid_lvl_q                <= cfg_wdata_i[DUTY_BITS-1:0];
        CFG_CEIL_LVL:      ceil_lvl_q               <= cfg_wdata_i[DUTY_BITS-1:0];
        CFG_SLIP_WAIT:     wait_cfg_q.slip_wait     <= cfg_wdata_i[WAIT_W-1:0];
        CFG_JUMP_WAIT:     wait_cfg_q.jump_wait     <= cfg_wdata_i[WAIT_W-1:0];
        CFG_RAMP_INTERVAL: wait_cfg_q.ramp_interval <= cfg_wdata_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign slip_lvl_o = slip_lvl_q;
  assign mid_lvl_o  = mid_lvl_q;
  assign ceil_lvl_o = ceil_lvl_q;
  assign wait_cfg_o = wait_cfg_q;

endmodule

`default_nettype wire

>>> hdl/mdr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mdr_core
  import mdr_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  wire logic [DUTY_BITS-1:0] base_duty_i,
  input  wire logic [DUTY_BITS-1:0] base_goal_i,
  input  wire logic [DUTY_BITS-1:0] ceil_lvl_i,
  input  wire logic [WAIT_W-1:0]    interval_i,
  output logic      [DUTY_BITS-1:0] step_duty_o,
  output phase_e                    step_phase_o,
  output logic      [WAIT_W-1:0]    step_wait_o
);

  logic [DUTY_BITS:0] step_next;
  logic               step_ok;

  // A step is taken only if it stays at or below both the goal and the ceiling.
  always_comb begin
    step_next    = {1'b0, base_duty_i} + (DUTY_BITS+1)'(1);
    step_ok      = (step_next <= {1'b0, base_goal_i}) && (step_next <= {1'b0, ceil_lvl_i});
    step_duty_o  = base_duty_i;
    step_phase_o = PH_IDLE;
    step_wait_o  = '0;
    if (step_ok) begin
      step_duty_o = step_next[DUTY_BITS-1:0];
      if (step_next[DUTY_BITS-1:0] != base_goal_i) begin
        step_phase_o = PH_RAMP;
        step_wait_o  = interval_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mdr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mdr_step
  import mdr_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 func_i,
  input  wire logic [DUTY_BITS-1:0] target_i,
  input  wire logic [DUTY_BITS-1:0] slip_lvl_i,
  input  wire logic [DUTY_BITS-1:0] mid_lvl_i,
  input  wire logic [DUTY_BITS-1:0] ceil_lvl_i,
  input  wait_cfg_t                 wait_cfg_i,
  output logic      [DUTY_BITS-1:0] duty_o,
  output logic                      busy_o
);

  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic [DUTY_BITS-1:0] goal_q, goal_d;
  phase_e               phase_q, phase_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;
  logic [DUTY_BITS-1:0] res_duty_q;
  logic                 res_busy_q;

  logic [DUTY_BITS-1:0] base_duty, base_goal;
  logic [DUTY_BITS-1:0] step_duty;
  phase_e               step_phase;
  logic [WAIT_W-1:0]    step_wait;
  logic [WAIT_W-1:0]    first_wait;
  logic [WAIT_W-1:0]    interval;

  // One ramp step, starting from the slip duty on a command or the current duty on a tick.
  always_comb begin
    base_duty = func_i ? slip_lvl_i : duty_q;
    base_goal = func_i ? target_i : goal_q;
    interval  = (wait_cfg_i.ramp_interval == '0) ? WAIT_W'(1) : wait_cfg_i.ramp_interval;
  end

  mdr_core #(.DUTY_BITS(DUTY_BITS)) u_core (
    .base_duty_i  (base_duty),
    .base_goal_i  (base_goal),
    .ceil_lvl_i   (ceil_lvl_i),
    .interval_i   (interval),
    .step_duty_o  (step_duty),
    .step_phase_o (step_phase),
    .step_wait_o  (step_wait)
  );

  always_comb begin
    first_wait = (slip_lvl_i <= mid_lvl_i) ? wait_cfg_i.slip_wait : wait_cfg_i.jump_wait;
    duty_d     = duty_q;
    goal_d     = goal_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    if (func_i) begin
      goal_d = target_i;
      if (target_i <= slip_lvl_i) begin
        duty_d  = target_i;
        phase_d = PH_IDLE;
        wait_d  = '0;
      end else if (first_wait == '0) begin
        duty_d  = step_duty;
        phase_d = step_phase;
        wait_d  = step_wait;
      end else begin
        duty_d  = slip_lvl_i;
        phase_d = PH_WAIT;
        wait_d  = first_wait;
      end
    end else begin
      case (phase_q)
        PH_WAIT, PH_RAMP: begin
          if (wait_q <= WAIT_W'(1)) begin
            duty_d  = step_duty;
            phase_d = step_phase;
            wait_d  = step_wait;
          end else begin
            wait_d = wait_q - WAIT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= '0;
      goal_q  <= '0;
      phase_q <= PH_IDLE;
      wait_q  <= '0;
    end else if (en_i) begin
      duty_q  <= duty_d;
      goal_q  <= goal_d;
      phase_q <= phase_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_duty_q <= duty_d;
      res_busy_q <= (phase_d == PH_WAIT) || (phase_d == PH_RAMP);
    end
  end

  assign duty_o = res_duty_q;
  assign busy_o = res_busy_q;

endmodule

`default_nettype wire

>>> hdl/mdr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mdr_checker
  import mdr_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [DUTY_BITS-1:0] duty_o,
  input wire logic                 busy_res_o
);

  // Checks that a valid result follows every transfer in.
  `ASSERT_IMPL(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o, ##2 out_valid_o)

  // The input side only stalls while a result waits and is not taken.
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // A waiting result holds its value.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(duty_o) && $stable(busy_res_o))

endmodule

bind motor_duty_ramp_with_slip_wait mdr_checker #(.DUTY_BITS(DUTY_BITS)) u_mdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .duty_o      (duty_o),
  .busy_res_o  (busy_res_o)
);

`default_nettype wire

>>> bench/tb_motor_duty_ramp_with_slip_wait.sv
`timescale 1ns / 1ps

module tb_motor_duty_ramp_with_slip_wait;
  import mdr_pkg::*;

  localparam int DUTY_W      = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              busy;
  } duty_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  func_i        = 1'b0;
  logic [DUTY_W-1:0]     target_duty_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [DUTY_W-1:0]     duty_o;
  logic                  busy_res_o;

  // Predictor copy of the configuration and of the ramp state.
  logic [DUTY_W-1:0] slip_lvl_r      = DUTY_W'(RST_SLIP_LVL);
  logic [DUTY_W-1:0] mid_lvl_r       = DUTY_W'(RST_MID_LVL);
  logic [DUTY_W-1:0] ceil_lvl_r      = DUTY_W'(RST_CEIL_LVL);
  logic [WAIT_W-1:0] slip_wait_r     = RST_SLIP_WAIT;
  logic [WAIT_W-1:0] jump_wait_r     = RST_JUMP_WAIT;
  logic [WAIT_W-1:0] ramp_interval_r = RST_RAMP_INTERVAL;

  logic [DUTY_W-1:0] duty_lvl   = '0;
  logic [DUTY_W-1:0] goal_lvl   = '0;
  phase_e            ramp_phase = PH_IDLE;
  logic [WAIT_W-1:0] wait_cnt   = '0;

  duty_result_t pending_duty_q[$];
  int           mismatches     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  motor_duty_ramp_with_slip_wait #(
    .DUTY_BITS(DUTY_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .target_duty_i(target_duty_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .duty_o       (duty_o),
    .busy_res_o   (busy_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_motor_duty_ramp_with_slip_wait: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void raise_duty_step();
    logic [DUTY_W:0] next_duty;
    next_duty = {1'b0, duty_lvl} + 1'b1;
    if (next_duty <= {1'b0, goal_lvl} && next_duty <= {1'b0, ceil_lvl_r}) begin
      duty_lvl = next_duty[DUTY_W-1:0];
      if (duty_lvl == goal_lvl) begin
        ramp_phase = PH_IDLE;
        wait_cnt   = '0;
      end else begin
        ramp_phase = PH_RAMP;
        wait_cnt   = (ramp_interval_r == '0) ? WAIT_W'(1) : ramp_interval_r;
      end
    end else begin
      ramp_phase = PH_IDLE;
      wait_cnt   = '0;
    end
  endfunction

  function automatic duty_result_t predict_duty(logic is_cmd, logic [DUTY_W-1:0] target);
    duty_result_t res;
    if (is_cmd) begin
      goal_lvl = target;
      if (target <= slip_lvl_r) begin
        duty_lvl   = target;
        ramp_phase = PH_IDLE;
        wait_cnt   = '0;
      end else begin
        duty_lvl   = slip_lvl_r;
        wait_cnt   = (duty_lvl <= mid_lvl_r) ? slip_wait_r : jump_wait_r;
        ramp_phase = PH_WAIT;
        if (wait_cnt == '0) begin
          raise_duty_step();
        end
      end
    end else if (ramp_phase == PH_WAIT || ramp_phase == PH_RAMP) begin
      if (wait_cnt <= WAIT_W'(1)) begin
        wait_cnt = '0;
        raise_duty_step();
      end else begin
        wait_cnt = wait_cnt - 1'b1;
      end
    end
    res.duty = duty_lvl;
    res.busy = (ramp_phase == PH_WAIT || ramp_phase == PH_RAMP);
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    duty_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_duty_q.size() == 0) begin
        report_mismatch("unexpected result, duty", -1, duty_o);
      end else begin
        want = pending_duty_q.pop_front();
        if (duty_o !== want.duty) begin
          report_mismatch("duty", want.duty, duty_o);
        end
        if (busy_res_o !== want.busy) begin
          report_mismatch("busy", want.busy, busy_res_o);
        end
      end
    end
  end

  task automatic send_item(logic is_cmd, logic [DUTY_W-1:0] target);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= is_cmd;
    target_duty_i <= target;
    do @(posedge clk_i); while (!in_ready_o);
    pending_duty_q.push_back(predict_duty(is_cmd, target));
  endtask

  task automatic send_tick();
    send_item(1'b0, DUTY_W'($urandom_range(0, 255)));
  endtask

  task automatic send_drive(logic [DUTY_W-1:0] target);
    send_item(1'b1, target);
  endtask

  // Stops the sender and waits until every predicted result has been seen.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_SLIP_LVL:      slip_lvl_r      = value[DUTY_W-1:0];
      CFG_MID_LVL:       mid_lvl_r       = value[DUTY_W-1:0];
      CFG_CEIL_LVL:      ceil_lvl_r      = value[DUTY_W-1:0];
      CFG_SLIP_WAIT:     slip_wait_r     = value;
      CFG_JUMP_WAIT:     jump_wait_r     = value;
      CFG_RAMP_INTERVAL: ramp_interval_r = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Duty registers get random upper bits, which the block must ignore.
  task automatic write_duty_reg(cfg_idx_e idx, logic [DUTY_W-1:0] value);
    write_reg(idx, {CFG_DATA_W'($urandom_range(0, 255)) << DUTY_W} | CFG_DATA_W'(value));
  endtask

  task automatic quiesce();
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_drive(8'd255);
    send_tick();
    send_drive(8'd0);
    send_drive(8'd128);
    send_tick();
  endtask

  task automatic test_zero_wait_ramp();
    quiesce();
    write_duty_reg(CFG_SLIP_LVL, 8'd10);
    write_duty_reg(CFG_MID_LVL, 8'd255);
    write_duty_reg(CFG_CEIL_LVL, 8'd255);
    write_reg(CFG_SLIP_WAIT, 16'd0);
    write_reg(CFG_RAMP_INTERVAL, 16'd2);
    send_drive(8'd13);
    repeat (4) send_tick();
  endtask

  task automatic test_jump_wait_ceiling();
    quiesce();
    write_duty_reg(CFG_SLIP_LVL, 8'd200);
    write_duty_reg(CFG_MID_LVL, 8'd100);
    write_duty_reg(CFG_CEIL_LVL, 8'd201);
    write_reg(CFG_JUMP_WAIT, 16'd1);
    write_reg(CFG_RAMP_INTERVAL, 16'd0);
    send_drive(8'd255);
    repeat (2) send_tick();
  endtask

  task automatic test_max_below_slip();
    quiesce();
    write_duty_reg(CFG_CEIL_LVL, 8'd50);
    write_reg(CFG_JUMP_WAIT, 16'd0);
    send_drive(8'd250);
    send_tick();
  endtask

  task automatic test_register_extremes();
    quiesce();
    write_duty_reg(CFG_SLIP_LVL, 8'd0);
    write_duty_reg(CFG_MID_LVL, 8'd0);
    write_duty_reg(CFG_CEIL_LVL, 8'd255);
    write_reg(CFG_SLIP_WAIT, 16'hFFFF);
    write_reg(CFG_JUMP_WAIT, 16'hFFFF);
    write_reg(CFG_RAMP_INTERVAL, 16'hFFFF);
    send_drive(8'd1);
    send_tick();
    send_drive(8'd0);
    quiesce();
    write_duty_reg(CFG_SLIP_LVL, 8'd255);
    send_drive(8'd255);
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty_setting();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return DUTY_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic load_random_settings();
    quiesce();
    write_duty_reg(CFG_SLIP_LVL, pick_duty_setting());
    write_duty_reg(CFG_MID_LVL, pick_duty_setting());
    write_duty_reg(CFG_CEIL_LVL, ($urandom_range(0, 2) == 0) ? pick_duty_setting()
                                                             : DUTY_W'($urandom_range(200, 255)));
    write_reg(CFG_SLIP_WAIT, WAIT_W'($urandom_range(0, 6)));
    write_reg(CFG_JUMP_WAIT, WAIT_W'($urandom_range(0, 6)));
    write_reg(CFG_RAMP_INTERVAL, WAIT_W'($urandom_range(0, 3)));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items, bit hold_mid);
    int offset;
    load_random_settings();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) begin
        wait_for_results();
      end
      if (i % 80 == 79) begin
        load_random_settings();
      end
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 3))
          0: send_drive(DUTY_W'($urandom_range(0, slip_lvl_r)));
          1: send_drive(DUTY_W'($urandom_range(0, 255)));
          default: begin
            offset = int'(slip_lvl_r) + $urandom_range(1, 12);
            send_drive((offset > 255) ? 8'd255 : DUTY_W'(offset));
          end
        endcase
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_zero_wait_ramp();
    test_jump_wait_ceiling();
    test_max_below_slip();
    test_register_extremes();
    test_random_traffic(0, 0, 250, 1'b0);
    test_random_traffic(88, 0, 250, 1'b1);
    test_random_traffic(0, 88, 250, 1'b0);
    test_random_traffic(20, 20, 250, 1'b1);

    quiesce();
    if (pending_duty_q.size() != 0) begin
      report_mismatch("results missing", 0, pending_duty_q.size());
    end
    if (mismatches == 0) begin
      $display("tb_motor_duty_ramp_with_slip_wait: done, clean");
    end else begin
      $display("tb_motor_duty_ramp_with_slip_wait: done, errors");
    end
    $finish;
  end

endmodule
